// File: hw/rtl/ldep_pkg.sv
// Shared types and constants for the lattice deposition block.
// Used by ldep_cell, ldep_regs and lattice_deposition_step; no dependencies.
package ldep_pkg;

  localparam int SITES_MAX   = 256;
  localparam int HEIGHT_BITS = 32;
  localparam int SITE_BITS   = $clog2(SITES_MAX);
  localparam int LEN_BITS    = 9;
  localparam int MODE_BITS   = 2;
  localparam int KIND_BITS   = 2;
  localparam int OUT_BITS    = 32;
  localparam int ADDR_BITS   = 3;

  typedef logic [HEIGHT_BITS-1:0] height_t;
  typedef logic [LEN_BITS-1:0]    len_t;
  typedef logic [SITE_BITS-1:0]   site_t;

  // Item kinds; the unused code acts as a read
  localparam logic [KIND_BITS-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_DEPOSIT = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_READ    = 2'd2;

  // Growth modes; the unused code acts as random deposition
  localparam logic [MODE_BITS-1:0] MODE_BALLISTIC = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_RANDOM    = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_RELAXED   = 2'd2;

  // Register indexes (byte address = 4 * index)
  localparam logic REG_GROWTH_MODE    = 1'b0;
  localparam logic REG_LATTICE_LENGTH = 1'b1;

  localparam logic [MODE_BITS-1:0] MODE_RESET   = MODE_BALLISTIC;
  localparam len_t                 LEN_RESET    = len_t'(256);
  localparam len_t                 LEN_MIN      = len_t'(3);
  localparam len_t                 LEN_MAX      = len_t'(SITES_MAX);

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [7:0]           site;
    logic [31:0]          height_value;
    logic                 tie_coin;
  } item_t;

  typedef struct packed {
    logic [7:0]  changed_site;
    logic [31:0] new_height;
    logic        saturated;
  } result_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] growth_mode;
    len_t                 lattice_length;
  } cfg_t;

endpackage

// File: hw/rtl/ldep_cell.sv
// One cell of the neighbor window: holds a height word and its full flag.
// Depends on ldep_pkg.
module ldep_cell (
  input  logic            clk,
  input  ldep_pkg::height_t d,
  output ldep_pkg::height_t q,
  output logic            q_full
);
  import ldep_pkg::*;

  // full flag is precomputed on entry so the saturation check is off the compare path
  always_ff @(posedge clk) begin
    q      <= d;
    q_full <= &d;
  end

endmodule

// File: hw/rtl/ldep_regs.sv
// APB-style configuration registers: growth_mode and lattice_length.
// Depends on ldep_pkg.
module ldep_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ldep_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output ldep_pkg::cfg_t                cfg
);
  import ldep_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.growth_mode    <= MODE_RESET;
      cfg.lattice_length <= LEN_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_GROWTH_MODE:    cfg.growth_mode    <= pwdata[MODE_BITS-1:0];
        REG_LATTICE_LENGTH: cfg.lattice_length <= pwdata[LEN_BITS-1:0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GROWTH_MODE:    prdata = 32'(cfg.growth_mode);
      REG_LATTICE_LENGTH: prdata = 32'(cfg.lattice_length);
      default:            prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/lattice_deposition_step.sv
// Top level: height memory, three-cell neighbor window and item sequencer.
// Depends on ldep_pkg, ldep_cell and ldep_regs.
//
//  channel   handshake               payload
//  item      start & !busy           item (kind, site, height_value, tie_coin)
//  result    done, one cycle         result (changed_site, new_height, saturated)
//  config    psel&penable&pwrite     paddr, pwdata / prdata, pready
//
// An item is taken only while idle. The height memory has one read port, so the
// left, centre and right words are read one per cycle and shifted through the
// window cells, then the new height is computed and written back.
// done pulses in the cycle after the write is issued; the receiver cannot stall it.
// rst is synchronous and clears the sequencer and the registers; the height
// memory holds nothing valid until loaded.
module lattice_deposition_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  ldep_pkg::item_t               item,
  output logic                          done,
  output ldep_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ldep_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ldep_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_L,
    ST_RD_C,
    ST_RD_R,
    ST_SETTLE,
    ST_EXEC
  } state_t;

  localparam int WIN = 3;

  state_t  state;
  cfg_t    cfg;

  // latched item
  logic [KIND_BITS-1:0] kind;
  site_t                s_site;
  site_t                l_site;
  site_t                r_site;
  logic                 in_range;
  height_t              load_val;
  logic                 coin;

  // item decode at accept
  len_t  n_used;
  len_t  s_ext;
  site_t l_next;
  site_t r_next;

  // memory
  height_t mem [SITES_MAX];
  height_t rdata;
  site_t   raddr;
  logic    we;
  site_t   waddr;
  height_t wdata;

  // window
  height_t cell_q    [WIN];
  logic    cell_full [WIN];

  // execute
  height_t hl, hc, hr;
  height_t bump_c, ball_max, relax_h, relax_bump;
  logic    relax_full, go_left, go_right;
  height_t h_low;
  site_t   relax_site;
  site_t   out_site;
  height_t out_h;
  logic    out_sat;

  ldep_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy = (state != ST_IDLE);

  always_comb begin
    if (cfg.lattice_length < LEN_MIN) begin
      n_used = LEN_MIN;
    end else if (cfg.lattice_length > LEN_MAX) begin
      n_used = LEN_MAX;
    end else begin
      n_used = cfg.lattice_length;
    end
    s_ext  = len_t'(item.site);
    l_next = (s_ext == '0) ? site_t'(n_used - len_t'(1)) : site_t'(s_ext - len_t'(1));
    r_next = (s_ext + len_t'(1) == n_used) ? '0 : site_t'(s_ext + len_t'(1));
  end

  // ---- height memory: one write port, one registered read port
  always_comb begin
    case (state)
      ST_RD_L: raddr = l_site;
      ST_RD_R: raddr = r_site;
      default: raddr = s_site;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // ---- neighbor window: rdata shifts in; after the settle cycle
  // cell 0 holds right, cell 1 centre, cell 2 left
  for (genvar i = 0; i < WIN; i++) begin : g_win
    if (i == 0) begin : g_head
      ldep_cell u_cell (.clk(clk), .d(rdata), .q(cell_q[i]), .q_full(cell_full[i]));
    end else begin : g_link
      ldep_cell u_cell (.clk(clk), .d(cell_q[i-1]), .q(cell_q[i]), .q_full(cell_full[i]));
    end
  end

  // ---- execute
  always_comb begin
    hr = cell_q[0];
    hc = cell_q[1];
    hl = cell_q[2];

    bump_c   = cell_full[1] ? hc : hc + height_t'(1);
    ball_max = bump_c;
    if (hl > ball_max) ball_max = hl;
    if (hr > ball_max) ball_max = hr;

    // relaxed: fall left if strictly lower, then right if strictly lower still;
    // a left/right tie after falling left goes to the coin
    go_left  = hl < hc;
    h_low    = go_left ? hl : hc;
    go_right = (hr < h_low) || (go_left && (hr == h_low) && coin);
    if (go_right) begin
      relax_site = r_site;
      relax_h    = hr;
      relax_full = cell_full[0];
    end else if (go_left) begin
      relax_site = l_site;
      relax_h    = hl;
      relax_full = cell_full[2];
    end else begin
      relax_site = s_site;
      relax_h    = hc;
      relax_full = cell_full[1];
    end
    relax_bump = relax_full ? relax_h : relax_h + height_t'(1);

    out_site = s_site;
    out_h    = '0;
    out_sat  = 1'b0;
    we       = 1'b0;
    waddr    = s_site;
    wdata    = load_val;

    if (in_range) begin
      case (kind)
        KIND_LOAD: begin
          out_h = load_val;
          we    = 1'b1;
        end
        KIND_DEPOSIT: begin
          we = 1'b1;
          case (cfg.growth_mode)
            MODE_BALLISTIC: begin
              out_h   = ball_max;
              out_sat = cell_full[1];
            end
            MODE_RELAXED: begin
              out_site = relax_site;
              out_h    = relax_bump;
              out_sat  = relax_full;
            end
            default: begin
              out_h   = bump_c;
              out_sat = cell_full[1];
            end
          endcase
          waddr = out_site;
          wdata = out_h;
        end
        default: begin
          out_h = hc;
        end
      endcase
    end

    if (state != ST_EXEC) begin
      we = 1'b0;
    end
  end

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RD_L;
          end
        end
        ST_RD_L:   state <= ST_RD_C;
        ST_RD_C:   state <= ST_RD_R;
        ST_RD_R:   state <= ST_SETTLE;
        ST_SETTLE: state <= ST_EXEC;
        ST_EXEC: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // item latch and result word
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      kind     <= item.kind;
      s_site   <= site_t'(item.site);
      l_site   <= l_next;
      r_site   <= r_next;
      in_range <= s_ext < n_used;
      load_val <= height_t'(item.height_value);
      coin     <= item.tie_coin;
    end
    if (state == ST_EXEC) begin
      result.changed_site <= 8'(out_site);
      result.new_height   <= OUT_BITS'(out_h);
      result.saturated    <= out_sat;
    end
  end

endmodule
